>>> design/tpct_pkg.sv
// shared types and constants for the task pool cancel tracker
`default_nettype none
package tpct_pkg;
    localparam logic [2:0] KIND_SUB_TASK   = 3'd0;
    localparam logic [2:0] KIND_SUB_GROUP  = 3'd1;
    localparam logic [2:0] KIND_START      = 3'd2;
    localparam logic [2:0] KIND_FINISH     = 3'd3;
    localparam logic [2:0] KIND_CAN_TASK   = 3'd4;
    localparam logic [2:0] KIND_CAN_GROUP  = 3'd5;
    localparam logic [2:0] KIND_QUERY      = 3'd6;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_BAD      = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] task_ident;
        logic [31:0] group_ident;
        logic [15:0] task_count;
        logic [5:0]  worker_slot;
    } req_t;

    typedef struct packed {
        logic       ok;
        logic [1:0] status;
    } rsp_t;
endpackage
`default_nettype wire

>>> design/tpct_if.sv
// valid/ready channel carrying one payload
`default_nettype none
interface tpct_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> design/tpct_table.sv
// one id table with a combinational read port and a single entry write port
`default_nettype none
module tpct_table #(
    parameter int ENTRIES = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [$clog2(ENTRIES)-1:0] rd_idx,
    output logic [31:0]                     rd_id,
    output logic [15:0]                     rd_wait,
    output logic [15:0]                     rd_run,
    output logic                            rd_canc,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ENTRIES)-1:0] wr_idx,
    input  wire logic [31:0]                wr_id,
    input  wire logic [15:0]                wr_wait,
    input  wire logic [15:0]                wr_run,
    input  wire logic                       wr_canc
);
    logic [31:0] ids_reg  [ENTRIES];
    logic [15:0] wait_reg [ENTRIES];
    logic [15:0] run_reg  [ENTRIES];
    logic [ENTRIES-1:0] canc_reg;

    assign rd_id   = ids_reg[rd_idx];
    assign rd_wait = wait_reg[rd_idx];
    assign rd_run  = run_reg[rd_idx];
    assign rd_canc = canc_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                ids_reg[i]  <= '0;
                wait_reg[i] <= '0;
                run_reg[i]  <= '0;
            end
            canc_reg <= '0;
        end
        else if (wr_en)
        begin
            ids_reg[wr_idx]  <= wr_id;
            wait_reg[wr_idx] <= wr_wait;
            run_reg[wr_idx]  <= wr_run;
            canc_reg[wr_idx] <= wr_canc;
        end
    end
endmodule
`default_nettype wire

>>> design/task_pool_cancel_tracker_core.sv
// top level: event sequencer with serial table search and worker slot store
//
// Usage: requests arrive on the req channel (kind, ids, count, worker slot),
// one response per request leaves on the rsp channel (ok, status).
// A request is taken only while the block is idle; the sequencer then reads
// the slot store, scans the selected table one entry per cycle looking for a
// live match and the lowest free entry, and writes back in the execute state.
// No new request is taken until its response has been taken. A query normally
// first loads its keys from the slot read before the scan starts.
// A request turned away before the scan (zero group count, slot out of range,
// query of an idle slot, unused kind) goes from the slot read state straight to
// the response state.
// The response is held in an output register until taken; a stalled receiver
// holds the block in that state and no new request is taken meanwhile.
// Reset clears every table entry, all slot busy bits and the sequencer state at once;
// no clearing pass follows, and the block is ready as soon as reset is released.
`default_nettype none
module task_pool_cancel_tracker_core #(
    parameter int TASK_ENTRIES  = 16,
    parameter int GROUP_ENTRIES = 16,
    parameter int WORKER_SLOTS  = 64
) (
    input wire logic clk,
    input wire logic rst_n,
    tpct_if.sink     req,
    tpct_if.source   rsp
);
    localparam int TW = $clog2(TASK_ENTRIES);
    localparam int GW = $clog2(GROUP_ENTRIES);
    localparam int IW = (TW > GW) ? TW : GW;
    localparam int SW = (WORKER_SLOTS > 64) ? 6 : $clog2(WORKER_SLOTS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SLOT = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;

    logic [2:0] state_reg, state_next;
    tpct_pkg::req_t r_reg;
    logic [IW:0] idx_reg, idx_next;
    logic grp_reg, grp_next;
    logic [31:0] key_reg, key_next;
    logic hit_reg, hit_next, fre_reg, fre_next;
    logic [IW-1:0] hidx_reg, hidx_next, fidx_reg, fidx_next;
    logic [31:0] htid_reg; // slot task for finish
    logic sbusy_reg;
    tpct_pkg::rsp_t out_reg, out_next;

    // slot store
    logic [WORKER_SLOTS-1:0] busy_reg;
    logic [31:0] stask_mem [WORKER_SLOTS];
    logic [31:0] sgrp_mem  [WORKER_SLOTS];
    logic [31:0] stask_rd, sgrp_rd;
    logic [SW-1:0] sidx;
    logic slot_ok;
    logic slot_set, slot_clr;

    assign slot_ok = ({26'd0, r_reg.worker_slot} < 32'(WORKER_SLOTS));
    assign sidx = r_reg.worker_slot[SW-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_SLOT)
        begin
            stask_rd <= stask_mem[sidx];
            sgrp_rd  <= sgrp_mem[sidx];
        end
        if (slot_set)
        begin
            stask_mem[sidx] <= r_reg.task_ident;
            sgrp_mem[sidx]  <= r_reg.group_ident;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= '0;
        else if (slot_set)
            busy_reg[sidx] <= 1'b1;
        else if (slot_clr)
            busy_reg[sidx] <= 1'b0;
    end

    // tables
    logic [31:0] t_id, g_id;
    logic [15:0] t_w, t_r, g_w, g_r;
    logic t_c, g_c;
    logic [IW-1:0] ridx;
    logic wr_en;
    logic [31:0] w_id;
    logic [15:0] w_w, w_r;
    logic w_c;
    logic [IW-1:0] w_idx;

    assign ridx = (state_reg == S_SCAN) ? idx_reg[IW-1:0] : hidx_reg;

    tpct_table #(.ENTRIES(TASK_ENTRIES)) u_task (
        .clk(clk), .rst_n(rst_n), .rd_idx(ridx[TW-1:0]),
        .rd_id(t_id), .rd_wait(t_w), .rd_run(t_r), .rd_canc(t_c),
        .wr_en(wr_en && !grp_reg), .wr_idx(w_idx[TW-1:0]), .wr_id(w_id),
        .wr_wait(w_w), .wr_run(w_r), .wr_canc(w_c)
    );
    tpct_table #(.ENTRIES(GROUP_ENTRIES)) u_group (
        .clk(clk), .rst_n(rst_n), .rd_idx(ridx[GW-1:0]),
        .rd_id(g_id), .rd_wait(g_w), .rd_run(g_r), .rd_canc(g_c),
        .wr_en(wr_en && grp_reg), .wr_idx(w_idx[GW-1:0]), .wr_id(w_id),
        .wr_wait(w_w), .wr_run(w_r), .wr_canc(w_c)
    );

    logic [31:0] c_id;
    logic [15:0] c_w, c_r;
    logic c_c, c_live;
    logic [IW:0] n_ent;
    assign c_id = grp_reg ? g_id : t_id;
    assign c_w  = grp_reg ? g_w : t_w;
    assign c_r  = grp_reg ? g_r : t_r;
    assign c_c  = grp_reg ? g_c : t_c;
    assign c_live = (c_w != 16'd0) || (c_r != 16'd0);
    assign n_ent = grp_reg ? (IW+1)'(GROUP_ENTRIES) : (IW+1)'(TASK_ENTRIES);

    logic [16:0] add_sum;
    logic [15:0] add_amt;
    assign add_amt = (r_reg.kind == tpct_pkg::KIND_SUB_GROUP) ? r_reg.task_count : 16'd1;
    assign add_sum = {1'b0, c_w} + {1'b0, add_amt};

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        grp_next = grp_reg;
        key_next = key_reg;
        hit_next = hit_reg;
        fre_next = fre_reg;
        hidx_next = hidx_reg;
        fidx_next = fidx_reg;
        out_next = out_reg;
        wr_en = 1'b0;
        w_idx = hidx_reg;
        w_id = c_id;
        w_w = c_w;
        w_r = c_r;
        w_c = c_c;
        slot_set = 1'b0;
        slot_clr = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                    state_next = S_SLOT;
            end
            S_SLOT:
            begin
                idx_next = '0;
                hit_next = 1'b0;
                fre_next = 1'b0;
                out_next = '{ok: 1'b0, status: tpct_pkg::ST_BAD};
                grp_next = (r_reg.group_ident != 32'd0);
                key_next = grp_next ? r_reg.group_ident : r_reg.task_ident;
                state_next = S_SCAN;
                case (r_reg.kind)
                    tpct_pkg::KIND_SUB_TASK:
                    begin
                        grp_next = 1'b0;
                        key_next = r_reg.task_ident;
                    end
                    tpct_pkg::KIND_SUB_GROUP:
                    begin
                        grp_next = 1'b1;
                        key_next = r_reg.group_ident;
                        if (r_reg.task_count == 16'd0)
                            state_next = S_RESP;
                    end
                    tpct_pkg::KIND_START, tpct_pkg::KIND_FINISH:
                    begin
                        if (!slot_ok)
                            state_next = S_RESP;
                    end
                    tpct_pkg::KIND_CAN_TASK:
                    begin
                        grp_next = 1'b0;
                        key_next = r_reg.task_ident;
                    end
                    tpct_pkg::KIND_CAN_GROUP:
                    begin
                        grp_next = 1'b1;
                        key_next = r_reg.group_ident;
                    end
                    tpct_pkg::KIND_QUERY:
                    begin
                        out_next = '{ok: 1'b0, status: tpct_pkg::ST_DONE};
                        if (!slot_ok || !busy_reg[sidx])
                            state_next = S_RESP;
                    end
                    default: state_next = S_RESP;
                endcase
            end
            S_SCAN:
            begin
                // query keys come from the slot read, ready now
                if (r_reg.kind == tpct_pkg::KIND_QUERY)
                begin
                    grp_next = (sgrp_rd != 32'd0);
                    key_next = grp_next ? sgrp_rd : stask_rd;
                    if (idx_reg == '0 && grp_next != grp_reg)
                        state_next = S_SCAN; // re-evaluate with the right table
                end
                if (r_reg.kind == tpct_pkg::KIND_QUERY && idx_reg == '0
                    && (grp_next != grp_reg || key_next != key_reg))
                begin
                    idx_next = '0;
                end
                else
                begin
                    if (!hit_reg && c_live && c_id == key_reg)
                    begin
                        hit_next = 1'b1;
                        hidx_next = idx_reg[IW-1:0];
                    end
                    if (!fre_reg && !c_live)
                    begin
                        fre_next = 1'b1;
                        fidx_next = idx_reg[IW-1:0];
                    end
                    idx_next = idx_reg + 1'b1;
                    if (idx_next == n_ent)
                        state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                out_next = '{ok: 1'b0, status: tpct_pkg::ST_DONE};
                case (r_reg.kind)
                    tpct_pkg::KIND_SUB_TASK, tpct_pkg::KIND_SUB_GROUP:
                    begin
                        if (hit_reg)
                        begin
                            if (add_sum[16])
                                out_next.status = tpct_pkg::ST_OVERFLOW;
                            else
                            begin
                                wr_en = 1'b1;
                                w_w = add_sum[15:0];
                                out_next.ok = 1'b1;
                            end
                        end
                        else if (fre_reg)
                        begin
                            wr_en = 1'b1;
                            w_idx = fidx_reg;
                            w_id = key_reg;
                            w_w = add_amt;
                            w_r = 16'd0;
                            w_c = 1'b0;
                            out_next.ok = 1'b1;
                        end
                        else
                            out_next.status = tpct_pkg::ST_FULL;
                    end
                    tpct_pkg::KIND_START:
                    begin
                        if (!hit_reg || c_w == 16'd0)
                            out_next.status = tpct_pkg::ST_BAD;
                        else if (c_c)
                        begin
                            wr_en = 1'b1;
                            w_w = c_w - 16'd1;
                            w_c = !(w_w == 16'd0 && c_r == 16'd0);
                        end
                        else if (c_r == tpct_pkg::COUNT_MAX)
                            out_next.status = tpct_pkg::ST_OVERFLOW;
                        else
                        begin
                            wr_en = 1'b1;
                            w_w = c_w - 16'd1;
                            w_r = c_r + 16'd1;
                            slot_set = !sbusy_reg;
                            out_next.ok = 1'b1;
                        end
                    end
                    tpct_pkg::KIND_FINISH:
                    begin
                        if (!sbusy_reg || htid_reg != r_reg.task_ident || !hit_reg
                            || c_r == 16'd0)
                            out_next.status = tpct_pkg::ST_BAD;
                        else
                        begin
                            wr_en = 1'b1;
                            slot_clr = 1'b1;
                            w_r = c_r - 16'd1;
                            if (c_c)
                                w_c = !(w_r == 16'd0 && c_w == 16'd0);
                            else
                                out_next.ok = 1'b1;
                        end
                    end
                    tpct_pkg::KIND_CAN_TASK, tpct_pkg::KIND_CAN_GROUP:
                    begin
                        if (!hit_reg)
                            out_next.status = tpct_pkg::ST_BAD;
                        else
                        begin
                            wr_en = 1'b1;
                            w_c = 1'b1;
                            out_next.ok = 1'b1;
                        end
                    end
                    default: out_next.ok = hit_reg && c_c; // query
                endcase
            end
            S_RESP:
            begin
                if (rsp.ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            r_reg <= req.data;
        if (state_reg == S_SLOT)
            sbusy_reg <= busy_reg[sidx];
        if (state_reg == S_SCAN)
            htid_reg <= stask_rd;
        idx_reg <= idx_next;
        grp_reg <= grp_next;
        key_reg <= key_next;
        hit_reg <= hit_next;
        fre_reg <= fre_next;
        hidx_reg <= hidx_next;
        fidx_reg <= fidx_next;
        out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire
